### hw/rtl/binary_to_decimal_ascii_top_assert.svh
// Assertion macros for the back stage of the binary to decimal ASCII converter.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, quiet during reset.
`define B2DA_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet during reset.
`define B2DA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/b2da_pkg.sv
// Package: constants, types and helpers of the binary to decimal ASCII converter.
package b2da_pkg;

  localparam int unsigned FIELD_BITS     = 32;
  localparam int unsigned DEF_VALUE_BITS = 32;
  localparam int unsigned NUM_DIGITS     = 10;
  localparam int unsigned DIG_IDX_W      = 4;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned CHAR_BITS      = 6;
  localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;

  typedef logic [3:0] bcd_digit_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } b2da_state_e;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  // Bits of the value that take part in the conversion.
  function automatic int unsigned eff_bits(int unsigned vb);
    return (vb < FIELD_BITS) ? vb : FIELD_BITS;
  endfunction

  // Double dabble correction of one BCD digit ahead of a shift.
  function automatic bcd_digit_t bcd_adjust(bcd_digit_t d);
    return (d >= 4'd5) ? bcd_digit_t'(d + 4'd3) : d;
  endfunction

endpackage

### hw/rtl/b2da_front.sv
// Front stage: accept a value, mask it to the working width and flag zero.
module b2da_front #(
  parameter int unsigned VALUE_BITS = b2da_pkg::DEF_VALUE_BITS
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  logic [b2da_pkg::FIELD_BITS-1:0]               value_i,
  output logic                                          push_o,
  output logic [b2da_pkg::eff_bits(VALUE_BITS):0]       push_data_o,
  input  b2da_pkg::queue_status_t                       q_stat_i
);
  import b2da_pkg::*;

  localparam int unsigned EFF_BITS = eff_bits(VALUE_BITS);

  logic                valid_q, valid_d;
  logic [EFF_BITS:0]   data_q, data_d;
  logic [EFF_BITS-1:0] masked;
  logic                accept;

  assign masked     = value_i[EFF_BITS-1:0];
  assign push_o     = valid_q && !q_stat_i.full;
  assign in_ready_o = !valid_q || !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d = 1'b1;
      data_d  = {(masked == '0), masked};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign push_data_o = data_q;

endmodule

### hw/rtl/b2da_queue.sv
// Short first-in first-out queue between the front and back stages.
module b2da_queue #(
  parameter int unsigned WIDTH = b2da_pkg::DEF_VALUE_BITS + 1,
  parameter int unsigned DEPTH = b2da_pkg::QUEUE_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [WIDTH-1:0]        push_data_i,
  input  logic                    pop_i,
  output logic [WIDTH-1:0]        pop_data_o,
  output b2da_pkg::queue_status_t status_o
);
  import b2da_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] advance(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= advance(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= advance(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= CNT_W'(count_q + 1'b1);
      end else if (do_pop && !do_push) begin
        count_q <= CNT_W'(count_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hw/rtl/b2da_back.sv
// Back stage: bit-serial double dabble conversion and digit emission.
module b2da_back #(
  parameter int unsigned VALUE_BITS = b2da_pkg::DEF_VALUE_BITS
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  output logic                                    pop_o,
  input  logic [b2da_pkg::eff_bits(VALUE_BITS):0] pop_data_i,
  input  b2da_pkg::queue_status_t                 q_stat_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [b2da_pkg::CHAR_BITS-1:0]          digit_char_o,
  output logic                                    last_o
);
  import b2da_pkg::*;

  `include "binary_to_decimal_ascii_top_assert.svh"

  localparam int unsigned EFF_BITS = eff_bits(VALUE_BITS);
  localparam int unsigned CNT_W    = $clog2(EFF_BITS + 1);

  b2da_state_e          state_q, state_d;
  logic [EFF_BITS-1:0]  bin_q, bin_d;
  bcd_digit_t           bcd_q [NUM_DIGITS];
  bcd_digit_t           bcd_d [NUM_DIGITS];
  bcd_digit_t           adj   [NUM_DIGITS];
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [DIG_IDX_W-1:0] idx_q, idx_d;
  logic                 lead_q, lead_d;
  logic                 out_valid_q, out_valid_d;
  bcd_digit_t           out_dig_q, out_dig_d;
  logic                 out_last_q, out_last_d;
  bcd_digit_t           cur;
  logic                 show, slot_free, emit, bcd_ok;

  assign cur       = bcd_q[idx_q];
  assign show      = lead_q || (cur != '0) || (idx_q == '0);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = bcd_adjust(bcd_q[i]);
    end
  end

  always_comb begin
    bcd_ok = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[i] > 4'd9) begin
        bcd_ok = 1'b0;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    lead_d      = lead_q;
    out_valid_d = out_valid_q;
    out_dig_d   = out_dig_q;
    out_last_d  = out_last_q;
    pop_o       = 1'b0;
    emit        = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o  = 1'b1;
          bin_d  = pop_data_i[EFF_BITS-1:0];
          for (int i = 0; i < NUM_DIGITS; i++) begin
            bcd_d[i] = '0;
          end
          cnt_d  = CNT_W'(EFF_BITS);
          idx_d  = DIG_IDX_W'(NUM_DIGITS - 1);
          lead_d = 1'b0;
          state_d = pop_data_i[EFF_BITS] ? ST_EMIT : ST_CONV;
        end
      end
      ST_CONV: begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
          if (i == 0) begin
            bcd_d[i] = {adj[i][2:0], bin_q[EFF_BITS-1]};
          end else begin
            bcd_d[i] = {adj[i][2:0], adj[i-1][3]};
          end
        end
        bin_d = bin_q << 1;
        cnt_d = CNT_W'(cnt_q - 1'b1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!show) begin
          idx_d = DIG_IDX_W'(idx_q - 1'b1);
        end else if (slot_free) begin
          emit        = 1'b1;
          out_valid_d = 1'b1;
          out_dig_d   = cur;
          out_last_d  = (idx_q == '0);
          lead_d      = 1'b1;
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = DIG_IDX_W'(idx_q - 1'b1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    bcd_q      <= bcd_d;
    cnt_q      <= cnt_d;
    idx_q      <= idx_d;
    lead_q     <= lead_d;
    out_dig_q  <= out_dig_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = CHAR_BITS'(ASCII_ZERO + {2'b00, out_dig_q});
  assign last_o       = out_last_q;

  `B2DA_ASSERT_IMPL(a_conv_cnt_live, (state_q == ST_CONV), (cnt_q != '0), "shift count ran out")
  `B2DA_ASSERT_IMPL(a_bcd_valid, (state_q != ST_IDLE), bcd_ok, "BCD digit out of range")
  `B2DA_ASSERT_IMPL(a_out_digit, out_valid_o, (out_dig_q <= 4'd9), "emitted digit above nine")
  `B2DA_ASSERT_NEXT(a_last_ends, (emit && out_last_d), (state_q == ST_IDLE), "value not closed")

endmodule

### hw/rtl/binary_to_decimal_ascii_top.sv
// Top level of the binary to decimal ASCII converter.
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+---------------------------
//  input   | in_valid_i / in_ready_o   | value_i[31:0]
//  output  | out_valid_o / out_ready_i | digit_char_o[5:0], last_o
//
//  One value leaves the queue, goes through one double dabble shift per value bit
//  (VALUE_BITS, at most 32), then walks the 10 digits: each leading zero is
//  dropped and each character is sent. Zero skips the shifting. The single
//  shift/add-3 loop in the back stage does the shifting.
//  Reset clears the control state only; nothing needs a clearing pass.
//  An output stall holds the digit walk at the next character to send, though
//  leading zeros are still dropped meanwhile; the front and queue keep taking
//  up to three further values.
module binary_to_decimal_ascii_top #(
  parameter int unsigned VALUE_BITS = b2da_pkg::DEF_VALUE_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [b2da_pkg::FIELD_BITS-1:0] value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [b2da_pkg::CHAR_BITS-1:0] digit_char_o,
  output logic                           last_o
);
  import b2da_pkg::*;

  // Only the low bits of the field carry the number.
  localparam int unsigned EFF_BITS = eff_bits(VALUE_BITS);

  // Queue entry: zero flag on top of the masked value.
  logic                push;
  logic [EFF_BITS:0]   push_data;
  logic                pop;
  logic [EFF_BITS:0]   pop_data;
  queue_status_t       q_stat;

  // Accept and classify each transaction.
  b2da_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .push_o      (push),
    .push_data_o (push_data),
    .q_stat_i    (q_stat)
  );

  // Hold classified values so either side can stall on its own.
  b2da_queue #(
    .WIDTH (EFF_BITS + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_stat)
  );

  // Convert and send characters, most significant first.
  b2da_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_o        (pop),
    .pop_data_i   (pop_data),
    .q_stat_i     (q_stat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

endmodule
